/* design/bol_pkg.sv */
// Shared types and constants for the bounded ordered record list.
`default_nettype none
package bol_pkg;

    localparam int KEY_W     = 32;
    localparam int PAY_W     = 64;
    localparam int REC_W     = KEY_W + PAY_W;
    localparam int FUNC_W    = 3;
    localparam int POS_IN_W  = 7;
    localparam int FPOS_W    = 6;
    localparam int COUNT_W   = 7;

    typedef enum logic [FUNC_W-1:0] {
        F_INS_FRONT = 3'd0,
        F_INS_REAR  = 3'd1,
        F_INS_AT    = 3'd2,
        F_DEL_FRONT = 3'd3,
        F_DEL_REAR  = 3'd4,
        F_DEL_AT    = 3'd5,
        F_DEL_KEY   = 3'd6,
        F_FIND      = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE     = 2'd0,
        S_SCAN     = 2'd1,
        S_SHIFT_UP = 2'd2,
        S_SHIFT_DN = 2'd3
    } t_state;

endpackage
`default_nettype wire

/* design/bol_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
`default_nettype none
module bol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* design/bounded_ordered_record_list_core.sv */
// Top level of the bounded ordered record list: sequencer, list count and result beat.
//
// Holds up to CAPACITY records ({32-bit key, 64-bit payload}) in list order in one
// simple dual-port RAM. A command beat is taken when start is high and busy is low;
// busy then stays high while the sequencer walks the RAM one entry per cycle through
// its single read port and single write port (read entry, write it one place over on
// the next cycle). Per command, with n the records held and p the position:
//   insert at p        : moves entries p to n - 1 up one place, tail first, then writes
//                        the new record at p (insert at rear moves nothing)
//   delete at p        : moves entries p + 1 to n - 1 down one place, front first
//                        (delete at rear: done at accept)
//   find key           : reads from the front to the first hit or the end of the list
//   delete by key at k : scans as find, then deletes at k as delete at p does
// Failed inserts and deletes (full, empty, bad position) finish at the accept edge.
// The result beat appears on o_done for exactly one cycle, the cycle after the last
// busy cycle (or after the accept edge when the command finishes there), and cannot
// be held off: the receiver must take it. A new command may be started in the same
// cycle as the result beat. The RAM needs no clearing pass: only entries below the
// count are ever used.
`default_nettype none
module bounded_ordered_record_list_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [bol_pkg::FUNC_W-1:0]      i_func,
    input  wire logic [bol_pkg::POS_IN_W-1:0]    i_position,
    input  wire logic [bol_pkg::KEY_W-1:0]       i_record_key,
    input  wire logic [bol_pkg::PAY_W-1:0]       i_record_payload,
    output logic                                 o_done,
    output logic                                 o_success,
    output logic                                 o_found,
    output logic [bol_pkg::FPOS_W-1:0]           o_found_position,
    output logic [bol_pkg::COUNT_W-1:0]          o_entry_count
);

    import bol_pkg::*;

    localparam int AW = $clog2(CAPACITY);       // RAM address bits
    localparam int CW = $clog2(CAPACITY + 1);   // count bits, holds CAPACITY
    localparam int PW = (CW > POS_IN_W) ? CW : POS_IN_W;

    // control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_pend, n_pend;     // a RAM read was issued last cycle
    logic            r_done;

    // working registers
    t_func           r_func, n_func;
    logic [KEY_W-1:0] r_key, n_key;
    logic [PAY_W-1:0] r_payload, n_payload;
    logic [CW-1:0]   r_pos, n_pos;       // insert position
    logic [CW-1:0]   r_idx, n_idx;       // walk index
    logic [AW-1:0]   r_wa, n_wa;         // address paired with the pending read
    logic            r_hit, n_hit;
    logic [AW-1:0]   r_where, n_where;

    // result registers
    logic                r_success, r_found;
    logic [FPOS_W-1:0]   r_fpos;
    logic [COUNT_W-1:0]  r_ecount;

    // finish signals
    logic            fin, fin_ok, fin_hit;
    logic [AW-1:0]   fin_where;
    logic [CW-1:0]   fin_count;

    // RAM side
    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [REC_W-1:0] ram_wdata, ram_rdata;
    logic [KEY_W-1:0] rd_key;

    // command decode
    t_func           in_func;
    logic [PW-1:0]   pos_ext, cnt_ext;
    logic            full, empty;
    logic            d_ok;
    t_state          d_next;

    logic [CW-1:0]   idx_m1;
    logic            match;

    assign busy    = (r_state != S_IDLE);
    assign in_func = t_func'(i_func);
    assign pos_ext = PW'(i_position);
    assign cnt_ext = PW'(r_count);
    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign idx_m1  = r_idx - CW'(1);
    assign rd_key  = ram_rdata[REC_W-1 -: KEY_W];
    assign match   = r_pend && (rd_key == r_key);

    bol_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Can the command proceed, and where does it go.
    always_comb begin
        d_ok   = 1'b0;
        d_next = S_IDLE;
        case (in_func)
            F_INS_FRONT, F_INS_REAR: begin
                d_ok   = !full;
                d_next = S_SHIFT_UP;
            end
            F_INS_AT: begin
                d_ok   = !full && (pos_ext <= cnt_ext);
                d_next = S_SHIFT_UP;
            end
            F_DEL_FRONT: begin
                d_ok   = !empty;
                d_next = S_SHIFT_DN;
            end
            F_DEL_REAR: begin
                d_ok   = !empty;
                d_next = S_IDLE;
            end
            F_DEL_AT: begin
                d_ok   = (pos_ext < cnt_ext);
                d_next = S_SHIFT_DN;
            end
            F_DEL_KEY, F_FIND: begin
                d_ok   = 1'b1;
                d_next = S_SCAN;
            end
            default: begin
                d_ok   = 1'b0;
                d_next = S_IDLE;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && d_ok) begin
                    n_state = d_next;
                end
            end
            S_SHIFT_UP: begin
                if (!(r_idx > r_pos) && !r_pend) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT_DN: begin
                if (!(r_idx < r_count) && !r_pend) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_state = (r_func == F_DEL_KEY) ? S_SHIFT_DN : S_IDLE;
                end else if (!(r_idx < r_count)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, RAM control and finish.
    always_comb begin
        n_count   = r_count;
        n_pend    = 1'b0;
        n_func    = r_func;
        n_key     = r_key;
        n_payload = r_payload;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_wa      = r_wa;
        n_hit     = r_hit;
        n_where   = r_where;
        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[AW-1:0];
        fin       = 1'b0;
        fin_ok    = 1'b0;
        fin_hit   = 1'b0;
        fin_where = '0;
        fin_count = r_count;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func    = in_func;
                    n_key     = i_record_key;
                    n_payload = i_record_payload;
                    n_hit     = 1'b0;
                    n_where   = '0;
                    n_idx     = r_count;
                    n_pos     = r_count;
                    if (!d_ok) begin
                        fin = 1'b1;
                    end else begin
                        case (in_func)
                            F_INS_FRONT: n_pos = '0;
                            F_INS_AT:    n_pos = pos_ext[CW-1:0];
                            F_DEL_FRONT: n_idx = CW'(1);
                            F_DEL_AT:    n_idx = pos_ext[CW-1:0] + CW'(1);
                            F_DEL_KEY, F_FIND: n_idx = '0;
                            F_DEL_REAR: begin
                                n_count   = r_count - CW'(1);
                                fin       = 1'b1;
                                fin_ok    = 1'b1;
                                fin_count = r_count - CW'(1);
                            end
                            default: n_pos = r_count;   // insert at rear
                        endcase
                    end
                end
            end

            // walk from the tail down to the gap, moving each record up one place
            S_SHIFT_UP: begin
                if (r_pend) begin
                    ram_we = 1'b1;
                end
                if (r_idx > r_pos) begin
                    ram_raddr = idx_m1[AW-1:0];
                    n_wa      = r_idx[AW-1:0];
                    n_idx     = idx_m1;
                    n_pend    = 1'b1;
                end else if (!r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos[AW-1:0];
                    ram_wdata = {r_key, r_payload};
                    n_count   = r_count + CW'(1);
                    fin       = 1'b1;
                    fin_ok    = 1'b1;
                    fin_count = r_count + CW'(1);
                end
            end

            // walk from past the hole to the tail, moving each record down one place
            S_SHIFT_DN: begin
                if (r_pend) begin
                    ram_we = 1'b1;
                end
                if (r_idx < r_count) begin
                    ram_raddr = r_idx[AW-1:0];
                    n_wa      = idx_m1[AW-1:0];
                    n_idx     = r_idx + CW'(1);
                    n_pend    = 1'b1;
                end else if (!r_pend) begin
                    n_count   = r_count - CW'(1);
                    fin       = 1'b1;
                    fin_ok    = 1'b1;
                    fin_hit   = r_hit;
                    fin_where = r_where;
                    fin_count = r_count - CW'(1);
                end
            end

            // compare one key per cycle, first hit wins
            S_SCAN: begin
                if (match) begin
                    n_hit   = 1'b1;
                    n_where = r_wa;
                    if (r_func == F_DEL_KEY) begin
                        n_idx = CW'(r_wa) + CW'(1);
                    end else begin
                        fin       = 1'b1;
                        fin_ok    = 1'b1;
                        fin_hit   = 1'b1;
                        fin_where = r_wa;
                    end
                end else if (r_idx < r_count) begin
                    ram_raddr = r_idx[AW-1:0];
                    n_wa      = r_idx[AW-1:0];
                    n_idx     = r_idx + CW'(1);
                    n_pend    = 1'b1;
                end else begin
                    fin = 1'b1;   // key absent
                end
            end

            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_key     <= n_key;
        r_payload <= n_payload;
        r_pos     <= n_pos;
        r_idx     <= n_idx;
        r_wa      <= n_wa;
        r_hit     <= n_hit;
        r_where   <= n_where;
        if (fin) begin
            r_success <= fin_ok;
            r_found   <= fin_hit;
            r_fpos    <= FPOS_W'(fin_where);
            r_ecount  <= COUNT_W'(fin_count);
        end
    end

    assign o_done           = r_done;
    assign o_success        = r_success;
    assign o_found          = r_found;
    assign o_found_position = r_fpos;
    assign o_entry_count    = r_ecount;

endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench for bounded_ordered_record_list_core: random list commands vs a queue-based list.
`timescale 1ns / 1ps
module tb;
    import bol_pkg::*;

    localparam int LIST_CAP = 64;

    // Expected fields of one result beat
    typedef struct packed {
        logic                success;
        logic                found;
        logic [FPOS_W-1:0]   fpos;
        logic [COUNT_W-1:0]  count;
    } t_outcome;

    // Shadow copy of the list; predicts each result and compares it
    class record_list_tracker;
        logic [KEY_W-1:0] keys[$];
        logic [PAY_W-1:0] payloads[$];
        t_outcome         pending_outcomes[$];
        int errors = 0;
        int commands = 0;
        int successes = 0;
        int key_hits = 0;
        int full_rejects = 0;
        int empty_rejects = 0;
        int peak = 0;
        int emptied = 0;

        function int held();
            return keys.size();
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction

        function logic [KEY_W-1:0] key_at(int idx);
            return keys[idx];
        endfunction

        // First index holding k, or -1
        function int seek(logic [KEY_W-1:0] k);
            foreach (keys[i])
                if (keys[i] == k) return i;
            return -1;
        endfunction

        // Called for every accepted command beat
        function void apply_command(t_func f, logic [POS_IN_W-1:0] p,
                                    logic [KEY_W-1:0] k, logic [PAY_W-1:0] d);
            t_outcome o;
            int n;
            int at;
            n = keys.size();
            o = '0;
            at = -1;
            commands++;
            case (f)
                F_INS_FRONT, F_INS_REAR, F_INS_AT: begin
                    if (f == F_INS_FRONT) at = 0;
                    else if (f == F_INS_REAR) at = n;
                    else if (int'(p) <= n) at = int'(p);
                    if (n >= LIST_CAP) full_rejects++;
                    if (n < LIST_CAP && at >= 0) begin
                        keys.insert(at, k);
                        payloads.insert(at, d);
                        o.success = 1'b1;
                    end
                end
                F_DEL_FRONT, F_DEL_REAR, F_DEL_AT: begin
                    if (f == F_DEL_FRONT) at = 0;
                    else if (f == F_DEL_REAR) at = n - 1;
                    else at = int'(p);
                    if (n == 0) empty_rejects++;
                    if (at >= 0 && at < n) begin
                        keys.delete(at);
                        payloads.delete(at);
                        o.success = 1'b1;
                    end
                end
                default: begin
                    // delete by key and find share the search
                    at = seek(k);
                    if (at >= 0) begin
                        o.success = 1'b1;
                        o.found   = 1'b1;
                        o.fpos    = at[FPOS_W-1:0];
                        key_hits++;
                        if (f == F_DEL_KEY) begin
                            keys.delete(at);
                            payloads.delete(at);
                        end
                    end
                end
            endcase
            if (o.success) successes++;
            if (keys.size() > peak) peak = keys.size();
            if (n > 0 && keys.size() == 0) emptied++;
            o.count = COUNT_W'(keys.size());
            pending_outcomes.push_back(o);
        endfunction

        // Called for every result beat
        function void check_result(logic s, logic fd, logic [FPOS_W-1:0] fp,
                                   logic [COUNT_W-1:0] c);
            t_outcome e;
            if (pending_outcomes.size() == 0) begin
                $error("result beat with no command outstanding");
                errors++;
                return;
            end
            e = pending_outcomes.pop_front();
            if (s !== e.success) begin
                $error("success: expected %0d, got %0d", e.success, s);
                errors++;
            end
            if (fd !== e.found) begin
                $error("found: expected %0d, got %0d", e.found, fd);
                errors++;
            end
            if (fp !== e.fpos) begin
                $error("found_position: expected %0d, got %0d", e.fpos, fp);
                errors++;
            end
            if (c !== e.count) begin
                $error("entry_count: expected %0d, got %0d", e.count, c);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [POS_IN_W-1:0]  i_position = '0;
    logic [KEY_W-1:0]     i_record_key = '0;
    logic [PAY_W-1:0]     i_record_payload = '0;
    logic                 o_done;
    logic                 o_success;
    logic                 o_found;
    logic [FPOS_W-1:0]    o_found_position;
    logic [COUNT_W-1:0]   o_entry_count;

    record_list_tracker tracker = new();
    int idle_pct = 0;   // chance, in percent, of an idle cycle before each command

    bounded_ordered_record_list_core #(
        .CAPACITY (LIST_CAP)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_position       (i_position),
        .i_record_key     (i_record_key),
        .i_record_payload (i_record_payload),
        .o_done           (o_done),
        .o_success        (o_success),
        .o_found          (o_found),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result beats can't be held off, so every o_done cycle is taken and checked
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            tracker.check_result(o_success, o_found, o_found_position, o_entry_count);
    end

    // Drive one command beat; returns just after the edge that accepts it.
    // start is assigned once per falling edge, so a back-to-back beat keeps it high.
    task automatic issue(t_func f, logic [POS_IN_W-1:0] p, logic [KEY_W-1:0] k,
                         logic [PAY_W-1:0] d);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start            = 1'b1;
        i_func           = f;
        i_position       = p;
        i_record_key     = k;
        i_record_payload = d;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.apply_command(f, p, k, d);
    endtask

    // Random command shaped by mode: 0 grow the list, 1 shrink it, 2 anything
    task automatic random_command(int mode);
        t_func f;
        logic [POS_IN_W-1:0] p;
        logic [KEY_W-1:0] k;
        int n;
        int r;
        n = tracker.held();
        r = $urandom_range(0, 99);
        if (mode == 0)
            f = (r < 85) ? t_func'($urandom_range(0, 2)) : t_func'($urandom_range(3, 7));
        else if (mode == 1)
            f = (r < 85) ? t_func'($urandom_range(3, 6))
                         : t_func'((r < 92) ? $urandom_range(0, 2) : F_FIND);
        else
            f = t_func'($urandom_range(0, 7));

        // Small key pool makes duplicates and hits common; full range covers every bit
        r = $urandom_range(0, 9);
        if (r < 5)
            k = $urandom_range(0, 15);
        else if (r < 8 && n > 0)
            k = tracker.key_at($urandom_range(0, n - 1));
        else
            k = $urandom;

        // Positions mostly near the list, sometimes exactly at the count, sometimes wild
        r = $urandom_range(0, 99);
        if (r < 80)
            p = POS_IN_W'($urandom_range(0, n + 1));
        else if (r < 90)
            p = POS_IN_W'(n);
        else
            p = POS_IN_W'($urandom_range(0, 127));

        issue(f, p, k, {$urandom, $urandom});
    endtask

    initial begin
        int seg;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty list, bad positions, append via position == count,
        // duplicate keys, missing keys, key and payload extremes
        issue(F_DEL_FRONT, 7'd0,   32'd0,        64'd0);
        issue(F_DEL_REAR,  7'd0,   32'd0,        64'd0);
        issue(F_DEL_AT,    7'd0,   32'd0,        64'd0);
        issue(F_DEL_KEY,   7'd0,   32'd0,        64'd0);
        issue(F_FIND,      7'd0,   32'd0,        64'd0);
        issue(F_INS_AT,    7'd1,   32'd1,        64'd1);
        issue(F_INS_AT,    7'd0,   32'd0,        64'd0);
        issue(F_INS_REAR,  7'd0,   32'hFFFF_FFFF, '1);
        issue(F_INS_FRONT, 7'd127, 32'd5,        64'h5555_5555_5555_5555);
        issue(F_INS_AT,    7'd3,   32'd7,        64'hAAAA_AAAA_AAAA_AAAA);
        issue(F_INS_AT,    7'd1,   32'hFFFF_FFFF, 64'd2);
        issue(F_FIND,      7'd0,   32'hFFFF_FFFF, 64'd0);
        issue(F_FIND,      7'd0,   32'h1234,     64'd0);
        issue(F_DEL_KEY,   7'd0,   32'h1234,     64'd0);
        issue(F_DEL_AT,    7'd127, 32'd0,        64'd0);
        issue(F_DEL_AT,    7'd5,   32'd0,        64'd0);
        issue(F_INS_AT,    7'd127, 32'd9,        64'd9);
        issue(F_DEL_KEY,   7'd0,   32'hFFFF_FFFF, 64'd0);
        issue(F_FIND,      7'd0,   32'hFFFF_FFFF, 64'd0);
        issue(F_DEL_AT,    7'd0,   32'd0,        64'd0);
        issue(F_DEL_FRONT, 7'd0,   32'd0,        64'd0);
        issue(F_DEL_REAR,  7'd0,   32'd0,        64'd0);
        issue(F_FIND,      7'd0,   32'd7,        64'd0);

        // Random: 50-command segments; two grow segments fill the list, two
        // shrink segments drain it, idle rate rotates among 0, 49 and 21 percent
        for (seg = 0; seg < 15; seg++) begin
            case (seg % 3)
                0: idle_pct = 0;
                1: idle_pct = 49;
                default: idle_pct = 21;
            endcase
            repeat (50) begin
                case (seg % 6)
                    0, 1: random_command(0);
                    3, 4: random_command(1);
                    default: random_command(2);
                endcase
            end
        end

        @(negedge i_clk);
        start = 1'b0;

        // Drain, then give the block time to show any stray beat
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (LIST_CAP + 8) @(posedge i_clk);

        $display("Ran %0d list commands: %0d succeeded, %0d key hits,",
                 tracker.commands, tracker.successes, tracker.key_hits);
        $display("%0d full and %0d empty rejects; list peaked at %0d, drained %0d times.",
                 tracker.full_rejects, tracker.empty_rejects, tracker.peak,
                 tracker.emptied);
        if (tracker.errors == 0)
            $display("bounded_ordered_record_list_core test passed");
        else
            $display("bounded_ordered_record_list_core test failed");
        $finish;
    end

    // Watchdog: the slowest legal run needs roughly a tenth of this
    initial begin
        #5_000_000;
        $display("bounded_ordered_record_list_core test failed");
        $finish;
    end

endmodule

/* files.f */
design/bol_pkg.sv
design/bol_ram.sv
design/bounded_ordered_record_list_core.sv
sim/tb.sv
